@@ rtl/terp_pkg.sv @@
// ----------------------------------------------------------------------------
// terp_pkg: shared types and constants for the translate/rotate pipeline
// Register codes, CORDIC lane type, arctangent table and fixed constants.
// ----------------------------------------------------------------------------
package terp_pkg;

   localparam int ANGLE_WIDTH  = 16;
   localparam int LANE_WIDTH   = 34;
   localparam int ZIN_WIDTH    = 36;
   localparam int CORDIC_STEPS = 30;
   localparam int SPLIT        = 24;
   localparam int CSR_IDX_W    = 3;

   localparam logic signed [LANE_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ZIN_WIDTH-1:0]  HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ZIN_WIDTH-1:0]  PI_Q30      = 36'sd3373259426;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROLL    = 3'd0,
      CSR_PITCH   = 3'd1,
      CSR_YAW     = 3'd2,
      CSR_SHIFT_X = 3'd3,
      CSR_SHIFT_Y = 3'd4,
      CSR_SHIFT_Z = 3'd5
   } csr_index_type;

   // one angle's rotator state as it moves down the cell row
   typedef struct packed {
      logic signed [LANE_WIDTH-1:0] x;
      logic signed [LANE_WIDTH-1:0] y;
      logic signed [LANE_WIDTH-1:0] z;
      logic                         neg;
   } lane_type;

   // roll, pitch, yaw
   typedef lane_type [2:0] lane_set_type;

   function automatic logic signed [LANE_WIDTH-1:0] atan_entry(input logic [4:0] idx);
      logic signed [LANE_WIDTH-1:0] r;
      case (idx)
         5'd0:  r = 34'sh3243F6A8;
         5'd1:  r = 34'sh1DAC6705;
         5'd2:  r = 34'sh0FADBAFC;
         5'd3:  r = 34'sh07F56EA6;
         5'd4:  r = 34'sh03FEAB76;
         5'd5:  r = 34'sh01FFD55B;
         5'd6:  r = 34'sh00FFFAAA;
         5'd7:  r = 34'sh007FFF55;
         5'd8:  r = 34'sh003FFFEA;
         5'd9:  r = 34'sh001FFFFD;
         5'd10: r = 34'sh000FFFFF;
         5'd11: r = 34'sh0007FFFF;
         5'd12: r = 34'sh0003FFFF;
         5'd13: r = 34'sh0001FFFF;
         5'd14: r = 34'sh0000FFFF;
         5'd15: r = 34'sh00007FFF;
         5'd16: r = 34'sh00003FFF;
         5'd17: r = 34'sh00001FFF;
         5'd18: r = 34'sh00000FFF;
         5'd19: r = 34'sh000007FF;
         5'd20: r = 34'sh000003FF;
         5'd21: r = 34'sh000001FF;
         5'd22: r = 34'sh000000FF;
         5'd23: r = 34'sh0000007F;
         5'd24: r = 34'sh0000003F;
         5'd25: r = 34'sh0000001F;
         5'd26: r = 34'sh0000000F;
         5'd27: r = 34'sh00000008;
         5'd28: r = 34'sh00000004;
         5'd29: r = 34'sh00000002;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/translate_then_euler_rotate_point.sv @@
// ----------------------------------------------------------------------------
// translate_then_euler_rotate_point: translate a point, rotate by Rz*Ry*Rx
// Pipelined point transform with CORDIC sine/cosine built per beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tdata: point_x, point_y, point_z
//  rsp     | out       | rsp_tvalid/tready  | tdata: out_x, out_y, out_z;
//          |           |                    | tuser: saturated
//  csr     | in        | csr_wen            | csr_index, csr_wdata
//
// One beat in and one beat out per clock while rsp is not stalled. The pipe is
// 30 CORDIC cells (one step each), 3 matrix stages and 3 dot-product stages,
// the last of which drives rsp, all moving in lockstep.
// Synchronous active-high reset empties the pipe and clears the configuration
// registers to 0; data registers keep whatever they hold.
// A stalled rsp beat freezes the whole pipe; req_tready drops only then.
// ----------------------------------------------------------------------------
module translate_then_euler_rotate_point import terp_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 18
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // point_x, point_y, point_z from bit 0 up, zero padded to bytes
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_x, out_y, out_z from bit 0 up, zero padded to bytes
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // saturated
   output logic [0:0]                            rsp_tuser,
   input  logic                                  csr_wen,
   input  logic [CSR_IDX_W-1:0]                  csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata
);

   localparam int DW = ((3*COORD_WIDTH+7)/8)*8;
   localparam int VW = COORD_WIDTH + 1;   // translated point never clips
   localparam int MW = COEF_WIDTH + 1;    // matrix entries reach about +-2

   // configuration registers
   logic signed [ANGLE_WIDTH-1:0] ang_ff [3];
   logic signed [COORD_WIDTH-1:0] shift_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            ang_ff[k]   <= '0;
            shift_ff[k] <= '0;
         end
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ROLL:    ang_ff[0]   <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_PITCH:   ang_ff[1]   <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_YAW:     ang_ff[2]   <= csr_wdata[ANGLE_WIDTH-1:0];
            CSR_SHIFT_X: shift_ff[0] <= csr_wdata;
            CSR_SHIFT_Y: shift_ff[1] <= csr_wdata;
            CSR_SHIFT_Z: shift_ff[2] <= csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // whole pipe advances unless the output beat is held
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // entry: angle to Q2.30, fold into +-pi/2, seed the rotator; add shift
   lane_set_type    seed;
   logic [3*VW-1:0] seed_vec;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [ZIN_WIDTH-1:0] z;
         z = ZIN_WIDTH'(ang_ff[k]) <<< 17;
         seed[k].neg = 1'b0;
         if (z > HALF_PI_Q30) begin
            z           = z - PI_Q30;
            seed[k].neg = 1'b1;
         end else if (z < -HALF_PI_Q30) begin
            z           = z + PI_Q30;
            seed[k].neg = 1'b1;
         end
         seed[k].x = CORDIC_GAIN;
         seed[k].y = '0;
         seed[k].z = z[LANE_WIDTH-1:0];
         seed_vec[k*VW +: VW] = VW'($signed(req_tdata[k*COORD_WIDTH +: COORD_WIDTH]))
                                + VW'(shift_ff[k]);
      end
   end

   // CORDIC row of cells
   lane_set_type    lanes [CORDIC_STEPS+1];
   logic [3*VW-1:0] vecs  [CORDIC_STEPS+1];
   logic [CORDIC_STEPS:0] cvalid;

   assign lanes[0]  = seed;
   assign vecs[0]   = seed_vec;
   assign cvalid[0] = req_tvalid;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      terp_cordic_cell #(.STEP(g), .VW(VW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cvalid[g]),
         .in_lanes  (lanes[g]),
         .in_vec    (vecs[g]),
         .out_valid (cvalid[g+1]),
         .out_lanes (lanes[g+1]),
         .out_vec   (vecs[g+1])
      );
   end

   logic            mvalid;
   logic [9*MW-1:0] mat;
   logic [3*VW-1:0] mvec;

   terp_matrix #(.COEF_WIDTH(COEF_WIDTH), .VW(VW), .MW(MW)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cvalid[CORDIC_STEPS]),
      .in_lanes  (lanes[CORDIC_STEPS]),
      .in_vec    (vecs[CORDIC_STEPS]),
      .out_valid (mvalid),
      .out_mat   (mat),
      .out_vec   (mvec)
   );

   logic [3*COORD_WIDTH-1:0] pts;
   logic                     sat;

   terp_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .VW(VW), .MW(MW))
   u_dot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mvalid),
      .in_mat    (mat),
      .in_vec    (mvec),
      .out_valid (rsp_tvalid),
      .out_pts   (pts),
      .out_sat   (sat)
   );

   assign rsp_tdata    = DW'(pts);
   assign rsp_tuser[0] = sat;

   // saturation flag only with a clamped coordinate
   localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (pts[0 +: COORD_WIDTH] == CMAX || pts[0 +: COORD_WIDTH] == CMIN ||
          pts[COORD_WIDTH +: COORD_WIDTH] == CMAX ||
          pts[COORD_WIDTH +: COORD_WIDTH] == CMIN ||
          pts[2*COORD_WIDTH +: COORD_WIDTH] == CMAX ||
          pts[2*COORD_WIDTH +: COORD_WIDTH] == CMIN))
      else $error("saturated flag without clamped coordinate");

   // reset empties the pipe
   assert property (@(posedge clock) reset |=> (!rsp_tvalid && !mvalid))
      else $error("pipe not empty after reset");

   // a stalled pipe keeps every cell's occupancy
   assert property (@(posedge clock) disable iff (reset)
      (!adv && !$past(reset)) |=> $stable(cvalid[CORDIC_STEPS:1]))
      else $error("cell occupancy changed during stall");

endmodule

@@ rtl/terp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// terp_cordic_cell: one rotation-mode CORDIC step for three angles
// Holds one beat's lanes and translated point; hands both to the next cell.
// ----------------------------------------------------------------------------
module terp_cordic_cell import terp_pkg::*; #(
   parameter int STEP = 0,
   parameter int VW   = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lane_set_type        in_lanes,
   input  logic [3*VW-1:0]     in_vec,
   output logic                out_valid,
   output lane_set_type        out_lanes,
   output logic [3*VW-1:0]     out_vec
);

   localparam logic [4:0] STEP_IDX = 5'(STEP);

   logic            valid_ff;
   lane_set_type    lanes_ff, lanes_in;
   logic [3*VW-1:0] vec_ff;

   always_comb begin
      lanes_in = in_lanes;
      for (int k = 0; k < 3; k++) begin
         if (!in_lanes[k].z[LANE_WIDTH-1]) begin
            lanes_in[k].x = in_lanes[k].x - (in_lanes[k].y >>> STEP);
            lanes_in[k].y = in_lanes[k].y + (in_lanes[k].x >>> STEP);
            lanes_in[k].z = in_lanes[k].z - atan_entry(STEP_IDX);
         end else begin
            lanes_in[k].x = in_lanes[k].x + (in_lanes[k].y >>> STEP);
            lanes_in[k].y = in_lanes[k].y - (in_lanes[k].x >>> STEP);
            lanes_in[k].z = in_lanes[k].z + atan_entry(STEP_IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         lanes_ff <= lanes_in;
         vec_ff   <= in_vec;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;
   assign out_vec   = vec_ff;

endmodule

@@ rtl/terp_matrix.sv @@
// ----------------------------------------------------------------------------
// terp_matrix: sine/cosine rounding and rotation matrix build
// Three register stages: round coefficients, pair products, final entries.
// ----------------------------------------------------------------------------
module terp_matrix import terp_pkg::*; #(
   parameter int COEF_WIDTH = 18,
   parameter int VW         = 33,
   parameter int MW         = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lane_set_type        in_lanes,
   input  logic [3*VW-1:0]     in_vec,
   output logic                out_valid,
   output logic [9*MW-1:0]     out_mat,
   output logic [3*VW-1:0]     out_vec
);

   localparam int F  = COEF_WIDTH - 2;
   localparam int RS = 30 - F;

   function automatic logic signed [MW-1:0] fmul(input logic signed [MW-1:0] a,
                                                 input logic signed [MW-1:0] b);
      logic signed [2*MW-1:0] p;
      p = a * b;
      p = p + (2*MW)'(1 <<< (F-1));
      return MW'(p >>> F);
   endfunction

   // stage A: rounded sine and cosine (0 roll, 1 pitch, 2 yaw)
   logic signed [MW-1:0] s_ff [3], c_ff [3], s_in [3], c_in [3];
   logic                 va_ff;
   logic [3*VW-1:0]      veca_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [LANE_WIDTH:0] xs, ys;
         xs = in_lanes[k].neg ? -(LANE_WIDTH+1)'(in_lanes[k].x) : (LANE_WIDTH+1)'(in_lanes[k].x);
         ys = in_lanes[k].neg ? -(LANE_WIDTH+1)'(in_lanes[k].y) : (LANE_WIDTH+1)'(in_lanes[k].y);
         xs = xs + (LANE_WIDTH+1)'(1 <<< (RS-1));
         ys = ys + (LANE_WIDTH+1)'(1 <<< (RS-1));
         c_in[k] = MW'(xs >>> RS);
         s_in[k] = MW'(ys >>> RS);
      end
   end

   // stage B: single products
   logic signed [MW-1:0] srsp_ff, crsp_ff, cpcy_ff, crsy_ff, srsy_ff, cpsy_ff;
   logic signed [MW-1:0] crcy_ff, srcy_ff, srcp_ff, crcp_ff, sy_ff, cy_ff, sp_ff;
   logic                 vb_ff;
   logic [3*VW-1:0]      vecb_ff;

   // stage C: matrix entries
   logic [9*MW-1:0] mat_ff, mat_in;
   logic            vc_ff;
   logic [3*VW-1:0] vecc_ff;

   always_comb begin
      mat_in[0*MW +: MW] = cpcy_ff;
      mat_in[1*MW +: MW] = fmul(srsp_ff, cy_ff) - crsy_ff;
      mat_in[2*MW +: MW] = fmul(crsp_ff, cy_ff) + srsy_ff;
      mat_in[3*MW +: MW] = cpsy_ff;
      mat_in[4*MW +: MW] = fmul(srsp_ff, sy_ff) + crcy_ff;
      mat_in[5*MW +: MW] = fmul(crsp_ff, sy_ff) - srcy_ff;
      mat_in[6*MW +: MW] = -sp_ff;
      mat_in[7*MW +: MW] = srcp_ff;
      mat_in[8*MW +: MW] = crcp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= s_in[k];
            c_ff[k] <= c_in[k];
         end
         veca_ff <= in_vec;
         srsp_ff <= fmul(s_ff[0], s_ff[1]);
         crsp_ff <= fmul(c_ff[0], s_ff[1]);
         cpcy_ff <= fmul(c_ff[1], c_ff[2]);
         crsy_ff <= fmul(c_ff[0], s_ff[2]);
         srsy_ff <= fmul(s_ff[0], s_ff[2]);
         cpsy_ff <= fmul(c_ff[1], s_ff[2]);
         crcy_ff <= fmul(c_ff[0], c_ff[2]);
         srcy_ff <= fmul(s_ff[0], c_ff[2]);
         srcp_ff <= fmul(s_ff[0], c_ff[1]);
         crcp_ff <= fmul(c_ff[0], c_ff[1]);
         sy_ff   <= s_ff[2];
         cy_ff   <= c_ff[2];
         sp_ff   <= s_ff[1];
         vecb_ff <= veca_ff;
         mat_ff  <= mat_in;
         vecc_ff <= vecb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign out_mat   = mat_ff;
   assign out_vec   = vecc_ff;

endmodule

@@ rtl/terp_dot.sv @@
// ----------------------------------------------------------------------------
// terp_dot: matrix times vector with rounding and saturation
// Split partial products, row sums, then round, clamp and flag.
// ----------------------------------------------------------------------------
module terp_dot import terp_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH  = 18,
   parameter int VW          = 33,
   parameter int MW          = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [9*MW-1:0]          in_mat,
   input  logic [3*VW-1:0]          in_vec,
   output logic                     out_valid,
   output logic [3*COORD_WIDTH-1:0] out_pts,
   output logic                     out_sat
);

   localparam int F     = COEF_WIDTH - 2;
   localparam int HI_W  = (VW > SPLIT) ? VW - SPLIT : 1;
   localparam int EXT_W = SPLIT + HI_W;
   localparam int PH_W  = MW + HI_W;
   localparam int PL_W  = MW + SPLIT + 1;
   localparam int TW    = MW + EXT_W + 4;

   localparam logic signed [TW-1:0] MAX_V = TW'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
   localparam logic signed [TW-1:0] MIN_V = -MAX_V - TW'(1);
   localparam logic signed [TW-1:0] HALF  = TW'(1 <<< (F-1));

   logic signed [PH_W-1:0]  ph_ff [9];
   logic signed [PL_W-1:0]  pl_ff [9];
   logic signed [PH_W+1:0]  hs_ff [3];
   logic signed [PL_W+1:0]  ls_ff [3];
   logic                    v1_ff, v2_ff, v3_ff;
   logic [3*COORD_WIDTH-1:0] pts_ff, pts_in;
   logic                    sat_ff, sat_in;

   always_comb begin
      sat_in = 1'b0;
      pts_in = '0;
      for (int k = 0; k < 3; k++) begin
         logic signed [TW-1:0] tot, q;
         tot = (TW'(hs_ff[k]) <<< SPLIT) + TW'(ls_ff[k]) + HALF;
         q   = tot >>> F;
         if (q > MAX_V) begin
            q      = MAX_V;
            sat_in = 1'b1;
         end else if (q < MIN_V) begin
            q      = MIN_V;
            sat_in = 1'b1;
         end
         pts_in[k*COORD_WIDTH +: COORD_WIDTH] = q[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               logic signed [EXT_W-1:0] ve;
               logic signed [HI_W-1:0]  vh;
               logic signed [SPLIT:0]   vl;
               ve = EXT_W'($signed(in_vec[j*VW +: VW]));
               vh = ve[EXT_W-1:SPLIT];
               vl = $signed({1'b0, ve[SPLIT-1:0]});
               ph_ff[3*r+j] <= PH_W'($signed(in_mat[(3*r+j)*MW +: MW]) * vh);
               pl_ff[3*r+j] <= PL_W'($signed(in_mat[(3*r+j)*MW +: MW]) * vl);
            end
         end
         for (int r = 0; r < 3; r++) begin
            hs_ff[r] <= (PH_W+2)'(ph_ff[3*r]) + (PH_W+2)'(ph_ff[3*r+1])
                        + (PH_W+2)'(ph_ff[3*r+2]);
            ls_ff[r] <= (PL_W+2)'(pl_ff[3*r]) + (PL_W+2)'(pl_ff[3*r+1])
                        + (PL_W+2)'(pl_ff[3*r+2]);
         end
         pts_ff <= pts_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_pts   = pts_ff;
   assign out_sat   = sat_ff;

endmodule
